// ----- src/motor_command_framer_crc16_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Motor command framer assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAMER_CRC16_UNIT_ASSERT_SVH
`define MOTOR_COMMAND_FRAMER_CRC16_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MCF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcf assertion failed");
// next-cycle implication
`define MCF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcf assertion failed");
`else
`define MCF_ASSERT_IMP(label, clk, rst, ante, cons)
`define MCF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/mcf_pkg.sv -----
// ----------------------------------------------------------------------------
// mcf_pkg
// Types, frame constants and the CRC16/Modbus byte update for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcf_pkg;

   // frame constants
   localparam logic [7:0]  FRAME_HEADER   = 8'h3E;
   localparam logic [7:0]  FRAME_SEQUENCE = 8'h00;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;

   localparam int MAX_PAYLOAD_BYTES_DEFAULT = 4;

   // byte position within a frame: at most 7 + 7 bytes
   localparam int POS_W = 4;

   typedef struct packed {
      logic [7:0]  command_code;
      logic [7:0]  motor_address;
      logic [2:0]  payload_length;
      logic [31:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_of_frame;
   } rsp_type;

   // queued command, length already saturated
   typedef struct packed {
      logic [7:0]  command_code;
      logic [7:0]  motor_address;
      logic [2:0]  length;
      logic [31:0] payload;
   } cmd_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic             busy;
      logic [POS_W-1:0] pos;
      logic [15:0]      crc;
   } back_status_type;

   // one byte of CRC16/Modbus, bit serial over eight steps
   function automatic logic [15:0] crc_feed(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- src/mcf_front.sv -----
// ----------------------------------------------------------------------------
// mcf_front
// Accepts commands, saturates the payload length and holds them in a
// two-entry queue for the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_front #(
   parameter int MAX_PAYLOAD_BYTES = mcf_pkg::MAX_PAYLOAD_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mcf_pkg::req_type req_payload,
   output logic                  cmd_valid,
   output mcf_pkg::cmd_type      cmd_head,
   input  wire logic             cmd_pop
);

   localparam int DEPTH = 2;

   mcf_pkg::cmd_type q_data_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   mcf_pkg::cmd_type cmd_new;

   // classify: clamp length to the configured maximum
   always_comb begin
      cmd_new.command_code  = req_payload.command_code;
      cmd_new.motor_address = req_payload.motor_address;
      cmd_new.payload       = req_payload.payload;
      if ({1'b0, req_payload.payload_length} > 4'(MAX_PAYLOAD_BYTES)) begin
         cmd_new.length = 3'(MAX_PAYLOAD_BYTES);
      end else begin
         cmd_new.length = req_payload.payload_length;
      end
   end

   assign req_ready = (count_ff != 2'(DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_head  = q_data_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_data_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

// ----- src/mcf_back.sv -----
// ----------------------------------------------------------------------------
// mcf_back
// Byte sequencer: walks one queued command through header, sequence,
// address, command, length, payload and CRC bytes, one byte per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcf_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   input  wire mcf_pkg::cmd_type     cmd_head,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mcf_pkg::rsp_type          rsp_payload,
   output mcf_pkg::back_status_type  status
);

   localparam int PW = mcf_pkg::POS_W;

   // fixed byte positions at the head of the frame
   localparam logic [PW-1:0] POS_HEADER   = PW'(0);
   localparam logic [PW-1:0] POS_SEQUENCE = PW'(1);
   localparam logic [PW-1:0] POS_ADDRESS  = PW'(2);
   localparam logic [PW-1:0] POS_COMMAND  = PW'(3);
   localparam logic [PW-1:0] POS_LENGTH   = PW'(4);
   localparam logic [PW-1:0] POS_PAYLOAD  = PW'(5);

   logic             busy_ff, busy_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   mcf_pkg::cmd_type cmd_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   mcf_pkg::rsp_type rsp_data_ff;

   logic             advance;
   logic             load;
   logic [PW-1:0]    crc_lo_pos;
   logic [PW-1:0]    pay_off;
   logic             is_last;
   logic             feed;
   logic [7:0]       byte_sel;

   assign advance    = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign crc_lo_pos = PW'(cmd_ff.length) + POS_PAYLOAD;
   assign is_last    = (pos_ff == crc_lo_pos + PW'(1));
   assign feed       = (pos_ff < crc_lo_pos);
   assign pay_off    = pos_ff - POS_PAYLOAD;
   assign load       = cmd_valid && (!busy_ff || (advance && is_last));
   assign cmd_pop    = load;

   // select the byte at the current position
   always_comb begin
      unique case (pos_ff)
         POS_HEADER:   byte_sel = mcf_pkg::FRAME_HEADER;
         POS_SEQUENCE: byte_sel = mcf_pkg::FRAME_SEQUENCE;
         POS_ADDRESS:  byte_sel = cmd_ff.motor_address;
         POS_COMMAND:  byte_sel = cmd_ff.command_code;
         POS_LENGTH:   byte_sel = {5'b0, cmd_ff.length};
         default: begin
            if (feed) begin
               // payload bytes past the 32-bit field go out as zero
               byte_sel = pay_off[2] ? 8'h00 : cmd_ff.payload[8*pay_off[1:0] +: 8];
            end else if (pos_ff == crc_lo_pos) begin
               byte_sel = crc_ff[7:0];
            end else begin
               byte_sel = crc_ff[15:8];
            end
         end
      endcase
   end

   // sequencer next state
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
         crc_in  = mcf_pkg::CRC_INIT;
      end else if (advance) begin
         pos_in = pos_ff + PW'(1);
         if (feed) begin
            crc_in = mcf_pkg::crc_feed(crc_ff, byte_sel);
         end
         if (is_last) begin
            busy_in = 1'b0;
            pos_in  = '0;
         end
      end
   end

   // output register valid
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         crc_ff       <= mcf_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command and output data
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_head;
      end
      if (advance) begin
         rsp_data_ff.frame_byte    <= byte_sel;
         rsp_data_ff.last_of_frame <= is_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign status.busy = busy_ff;
   assign status.pos  = pos_ff;
   assign status.crc  = crc_ff;

endmodule

`default_nettype wire

// ----- src/motor_command_framer_crc16_unit.sv -----
// ----------------------------------------------------------------------------
// motor_command_framer_crc16_unit
// RS485 motor command framer with CRC16/Modbus trailer.
// ----------------------------------------------------------------------------
// Each accepted command becomes a frame of 7 + length bytes (length clamped
// to MAX_PAYLOAD_BYTES): 0x3E, 0x00, address, command, length, payload low
// byte first, CRC low, CRC high; the CRC high byte carries last_of_frame.
// Bytes leave at one per cycle unless the output stalls, set by the byte
// sequencer, which updates the CRC one byte per cycle; back-to-back frames
// follow with no gap. An idle unit loads a queued command into the sequencer,
// then registers its first byte at the output. A two-entry command queue lets
// new commands transfer while a frame is still going out.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_command_framer_crc16_unit_assert.svh"

module motor_command_framer_crc16_unit #(
   parameter int MAX_PAYLOAD_BYTES = mcf_pkg::MAX_PAYLOAD_BYTES_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mcf_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mcf_pkg::rsp_type      rsp_payload
);

   logic                     cmd_valid;
   logic                     cmd_pop;
   mcf_pkg::cmd_type         cmd_head;
   mcf_pkg::back_status_type back_status;

   // command intake and queue
   mcf_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop)
   );

   // frame byte sequencer
   mcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_head   (cmd_head),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .status     (back_status)
   );

   // an accepted command is queued until the sequencer takes it
   `MCF_ASSERT_NEXT(a_push_queued, clock, reset, req_valid && req_ready, cmd_valid)
   // an idle sequencer takes a waiting command at once
   `MCF_ASSERT_NEXT(a_idle_loads, clock, reset, !back_status.busy && cmd_valid, back_status.busy)
   // every frame starts at position zero with a fresh CRC
   `MCF_ASSERT_IMP(a_frame_start, clock, reset, $rose(back_status.busy), (back_status.pos == '0) && (back_status.crc == mcf_pkg::CRC_INIT))
   // the sequencer only pops while a command is waiting
   `MCF_ASSERT_IMP(a_pop_valid, clock, reset, cmd_pop, cmd_valid)

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: motor command framer testbench
// Sends motor commands into the framer over valid/ready and compares every
// frame byte that comes out with a frame built in the bench: header,
// sequence, address, command, clamped length, payload low byte first and
// the CRC16/Modbus trailer, with last_of_frame on the final byte. Both
// sides idle at random; the receiver also holds off for long stretches so
// that the command queue fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN         = mcf_pkg::MAX_PAYLOAD_BYTES_DEFAULT;
   localparam int RANDOM_COMMANDS = 280;
   localparam int MAX_IDLE        = 11;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_SETTLE    = 24;
   localparam int REPORT_LIMIT    = 10;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   mcf_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   mcf_pkg::rsp_type rsp_payload;

   // frame bytes still owed by the block, oldest first
   mcf_pkg::rsp_type frame_bytes_due[$];
   mcf_pkg::rsp_type want_byte;

   bit idle_on       = 1'b1;
   int rsp_hold_req  = 0;
   int rsp_hold_left = 0;
   int rsp_gap_left  = 0;
   int cycle_count   = 0;

   int commands_sent      = 0;
   int clamped_commands   = 0;
   int bytes_checked      = 0;
   int byte_mismatches    = 0;
   int input_stall_cycles = 0;
   int holdoff_runs       = 0;

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   motor_command_framer_crc16_unit #(
      .MAX_PAYLOAD_BYTES(MAX_LEN)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // CRC16/Modbus, one data bit folded in per shift
   function automatic logic [15:0] crc16_modbus_byte(input logic [15:0] crc_in,
                                                     input logic [7:0]  data);
      logic [15:0] crc;
      logic        feedback;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         feedback = crc[0] ^ data[i];
         crc      = crc >> 1;
         if (feedback) begin
            crc = crc ^ mcf_pkg::CRC_POLY;
         end
      end
      return crc;
   endfunction

   // queue the full frame that one accepted command must produce
   function automatic void build_expected_frame(input mcf_pkg::req_type cmd);
      logic [7:0]       frame[$];
      logic [15:0]      crc;
      int               len;
      mcf_pkg::rsp_type entry;
      len = (cmd.payload_length > MAX_LEN) ? MAX_LEN : int'(cmd.payload_length);
      if (cmd.payload_length > MAX_LEN) begin
         clamped_commands++;
      end
      frame = {mcf_pkg::FRAME_HEADER, mcf_pkg::FRAME_SEQUENCE, cmd.motor_address,
               cmd.command_code, 8'(len)};
      for (int i = 0; i < len; i++) begin
         frame.push_back((i < 4) ? cmd.payload[8*i +: 8] : 8'h00);
      end
      crc = mcf_pkg::CRC_INIT;
      foreach (frame[i]) begin
         crc = crc16_modbus_byte(crc, frame[i]);
      end
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      foreach (frame[i]) begin
         entry.frame_byte    = frame[i];
         entry.last_of_frame = (i == frame.size() - 1);
         frame_bytes_due.push_back(entry);
      end
   endfunction

   function automatic mcf_pkg::req_type random_command();
      mcf_pkg::req_type cmd;
      cmd.command_code  = 8'($urandom);
      cmd.motor_address = 8'($urandom);
      cmd.payload       = $urandom;
      // mostly legal lengths, some oversize ones to hit the clamp
      if ($urandom_range(0, 7) < 6) begin
         cmd.payload_length = 3'($urandom_range(0, MAX_LEN));
      end else begin
         cmd.payload_length = 3'($urandom_range(MAX_LEN + 1, 7));
      end
      return cmd;
   endfunction

   // one command transfer; valid stays up if the next command follows at once
   task automatic send_command(input mcf_pkg::req_type cmd);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (!req_ready);
      build_expected_frame(cmd);
      commands_sent++;
   endtask

   // sender goes quiet until every owed byte has arrived
   task automatic wait_frames_out();
      req_valid <= 1'b0;
      while (frame_bytes_due.size() != 0) @(posedge clock);
   endtask

   // receiver: random gap after each transfer, plus requested long hold-offs
   always @(posedge clock) begin
      if (rsp_hold_req > 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
         holdoff_runs++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_gap_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // frame byte checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_bytes_due.size() == 0) begin
            byte_mismatches++;
            if (byte_mismatches <= REPORT_LIMIT) begin
               $display("%0t: unexpected byte %02h last %0b, nothing owed", $realtime,
                        rsp_payload.frame_byte, rsp_payload.last_of_frame);
            end
         end else begin
            want_byte = frame_bytes_due.pop_front();
            bytes_checked++;
            if (rsp_payload.frame_byte !== want_byte.frame_byte ||
                rsp_payload.last_of_frame !== want_byte.last_of_frame) begin
               byte_mismatches++;
               if (byte_mismatches <= REPORT_LIMIT) begin
                  $display("%0t: byte %0d expected %02h last %0b, got %02h last %0b",
                           $realtime, bytes_checked, want_byte.frame_byte,
                           want_byte.last_of_frame, rsp_payload.frame_byte,
                           rsp_payload.last_of_frame);
               end
            end
         end
      end
   end

   // input stalls, to show the queue actually filled
   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready) begin
         input_stall_cycles++;
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
               frame_bytes_due.size());
      $display("Simulation FAILED");
      $finish;
   end

   // field extremes, every length code including the clamped ones
   task automatic test_length_extremes();
      idle_on = 1'b1;
      send_command(mcf_pkg::req_type'{8'h00, 8'h00, 3'd0, 32'h0000_0000});
      send_command(mcf_pkg::req_type'{8'hFF, 8'hFF, 3'd0, 32'hFFFF_FFFF});
      send_command(mcf_pkg::req_type'{8'h80, 8'h01, 3'd1, 32'h0000_0080});
      send_command(mcf_pkg::req_type'{8'h01, 8'h80, 3'd1, 32'hFFFF_FFFF});
      send_command(mcf_pkg::req_type'{8'h55, 8'hAA, 3'd2, 32'h0000_A55A});
      send_command(mcf_pkg::req_type'{8'hAA, 8'h55, 3'd2, 32'hFFFF_0000});
      // speed set in position loop: mode byte then speed x10, low byte first
      send_command(mcf_pkg::req_type'{8'hA2, 8'h01, 3'd3, 32'h003A_9801});
      send_command(mcf_pkg::req_type'{8'h7F, 8'hFE, 3'd3, 32'hFF00_FFFF});
      send_command(mcf_pkg::req_type'{8'h3E, 8'h3E, 3'd4, 32'h1122_3344});
      send_command(mcf_pkg::req_type'{8'hC3, 8'h3C, 3'd4, 32'hFFFF_FFFF});
      send_command(mcf_pkg::req_type'{8'h00, 8'hFF, 3'd4, 32'h8000_0000});
      send_command(mcf_pkg::req_type'{8'hFF, 8'h00, 3'd4, 32'h0000_0001});
      send_command(mcf_pkg::req_type'{8'h10, 8'h20, 3'd4, 32'h0000_0000});
      // oversize lengths: clamp to the maximum payload
      send_command(mcf_pkg::req_type'{8'h5A, 8'hA5, 3'd5, 32'hA5C3_5A3C});
      send_command(mcf_pkg::req_type'{8'hA5, 8'h5A, 3'd6, 32'h0123_4567});
      send_command(mcf_pkg::req_type'{8'hFF, 8'hFF, 3'd7, 32'hFFFF_FFFF});
      send_command(mcf_pkg::req_type'{8'h00, 8'h00, 3'd7, 32'h0000_0000});
      wait_frames_out();
   endtask

   // receiver stops for a long stretch while commands keep coming
   task automatic test_receiver_holdoff();
      idle_on      = 1'b0;
      rsp_hold_req = 160;
      for (int i = 0; i < 12; i++) begin
         send_command(random_command());
      end
      wait_frames_out();
      idle_on = 1'b1;
   endtask

   // bursts separated by full drains of the output
   task automatic test_sender_drain_pause();
      for (int burst = 0; burst < 3; burst++) begin
         for (int i = 0; i < 4; i++) begin
            send_command(random_command());
         end
         wait_frames_out();
      end
   endtask

   // random commands, idling switched on and off in stretches
   task automatic test_random_commands();
      for (int i = 0; i < RANDOM_COMMANDS; i++) begin
         if (i % 40 == 0) begin
            idle_on = ((i / 40) % 2 == 0);
         end
         if (i == 200) begin
            rsp_hold_req = 120;
         end
         send_command(random_command());
      end
      wait_frames_out();
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_length_extremes();
      test_receiver_holdoff();
      test_sender_drain_pause();
      test_random_commands();
      repeat (DRAIN_SETTLE) @(posedge clock);
      $display("%0d commands framed (%0d with oversize length), %0d frame bytes compared",
               commands_sent, clamped_commands, bytes_checked);
      $display("%0d receiver hold-offs, %0d input stall cycles, %0d mismatches",
               holdoff_runs, input_stall_cycles, byte_mismatches);
      if (byte_mismatches == 0 && frame_bytes_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- motor_command_framer_crc16_unit.f -----
+incdir+src
src/mcf_pkg.sv
src/mcf_front.sv
src/mcf_back.sv
src/motor_command_framer_crc16_unit.sv
tb/sv/tb_top.sv
